// ----- hw/rtl/etl_pkg.sv -----
// ----------------------------------------------------------------------------
// Expression token lexer package
// Request types, token kinds, character constants and character classes.
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam int MAX_TOKEN_CHARS = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_char;
    logic       last;
  } out_item_t;

  localparam logic [2:0] KIND_OP      = 3'd0;
  localparam logic [2:0] KIND_INT     = 3'd1;
  localparam logic [2:0] KIND_REAL    = 3'd2;
  localparam logic [2:0] KIND_IDENT   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_numchar(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || c == CH_POINT;
  endfunction

  function automatic logic is_idchar(input logic [7:0] c);
    return is_letter(c) || is_numchar(c) || c == CH_USCORE;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_EQUAL || c == CH_PLUS ||
           c == CH_MINUS  || c == CH_STAR   || c == CH_SLASH || c == CH_PERCENT ||
           c == CH_CARET  || c == CH_SEMI   || c == CH_COMMA || c == CH_COLON;
  endfunction

endpackage

// ----- hw/rtl/expression_token_lexer.sv -----
// ----------------------------------------------------------------------------
// Expression token lexer
// Cuts a character stream into operator, number, identifier, unknown and end tokens.
// ----------------------------------------------------------------------------
// A character that is skipped, opens or extends a token, or is a one-character
// token is taken in the idle state. A character that ends a buffered token waits
// while the token is read out of the buffer memory one character per cycle
// through its single read port, when the output is not stalled, and is then
// handled itself in the tail state. End of input behaves in the same way and
// is followed by the end token. Results are held in an output register, so a
// stalled result delays the next request by the length of the stall.
module expression_token_lexer #(
  parameter int TOKEN_CHARS = etl_pkg::MAX_TOKEN_CHARS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  etl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output etl_pkg::out_item_t out_data
);
  import etl_pkg::*;

  localparam int LEN_W = $clog2(TOKEN_CHARS + 1);
  localparam int AW    = $clog2(TOKEN_CHARS);

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  etl_ctrl #(
    .TOKEN_CHARS (TOKEN_CHARS),
    .LEN_W       (LEN_W),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  etl_tokbuf #(
    .DEPTH (TOKEN_CHARS),
    .AW    (AW)
  ) u_tokbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- hw/rtl/etl_tokbuf.sv -----
// ----------------------------------------------------------------------------
// Token buffer
// Single-port-write, single-port-read character store with registered read.
// ----------------------------------------------------------------------------
module etl_tokbuf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/etl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lexer control
// Scan state, token length and the sequencer that drains the token buffer.
// ----------------------------------------------------------------------------
module etl_ctrl #(
  parameter int TOKEN_CHARS = etl_pkg::MAX_TOKEN_CHARS,
  parameter int LEN_W       = 6,
  parameter int AW          = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  etl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output etl_pkg::out_item_t out_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [7:0]         rd_data
);
  import etl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_TAIL} state_t;
  typedef enum logic [1:0] {M_IDLE, M_COMMENT, M_NUMBER, M_IDENT} mode_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(TOKEN_CHARS);

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             seen_r, seen_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             end_r, end_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic       accept, slot_free, open_tok, cont, do_handle, is_last;
  logic [7:0] sel_ch;
  logic       sel_end;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign open_tok  = (mode_r == M_NUMBER) || (mode_r == M_IDENT);
  assign cont      = (mode_r == M_NUMBER) ? is_numchar(in_data.ch) : is_idchar(in_data.ch);
  assign is_last   = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;
  assign sel_ch    = (state_r == S_IDLE) ? in_data.ch : ch_r;
  assign sel_end   = (state_r == S_IDLE) ? in_data.is_end : end_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    idx_nxt       = idx_r;
    ch_nxt        = ch_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = len_r[AW-1:0];
    wr_data       = sel_ch;
    rd_en         = 1'b0;
    rd_addr       = '0;
    do_handle     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ch_nxt  = in_data.ch;
          end_nxt = in_data.is_end;
          if (in_data.is_end) begin
            if (open_tok) begin
              rd_en     = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_FLUSH;
            end else begin
              do_handle = 1'b1;
            end
          end else if (mode_r == M_COMMENT) begin
            if (in_data.ch == CH_NL) begin
              mode_nxt = M_IDLE;
            end
          end else if (open_tok) begin
            if (cont && len_r < MAX_LEN) begin
              wr_en   = 1'b1;
              len_nxt = len_r + LEN_W'(1);
              if (mode_r == M_NUMBER && in_data.ch == CH_POINT) begin
                seen_nxt = 1'b1;
              end
            end else begin
              // The character ends the open token; it is handled once the token is out.
              rd_en     = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_FLUSH;
            end
          end else begin
            do_handle = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = (mode_r == M_NUMBER) ? (seen_r ? KIND_REAL : KIND_INT)
                                                        : KIND_IDENT;
          out_data_nxt.text_char = rd_data;
          out_data_nxt.last      = is_last;
          if (is_last) begin
            mode_nxt  = M_IDLE;
            len_nxt   = '0;
            seen_nxt  = 1'b0;
            state_nxt = S_TAIL;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      S_TAIL: begin
        do_handle = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Treatment of a character with no token open, or of end of input.
    if (do_handle) begin
      if (sel_end) begin
        mode_nxt = M_IDLE;
        len_nxt  = '0;
        seen_nxt = 1'b0;
      end
      if (sel_end || is_operator(sel_ch) || !(is_blank(sel_ch) || sel_ch == CH_HASH ||
          is_numchar(sel_ch) || is_letter(sel_ch))) begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = sel_end ? KIND_END :
                                   (is_operator(sel_ch) ? KIND_OP : KIND_UNKNOWN);
          out_data_nxt.text_char = sel_end ? 8'h00 : sel_ch;
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end
      end else begin
        state_nxt = S_IDLE;
        if (sel_ch == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else if (is_numchar(sel_ch) || is_letter(sel_ch)) begin
          wr_en    = 1'b1;
          wr_addr  = '0;
          mode_nxt = is_numchar(sel_ch) ? M_NUMBER : M_IDENT;
          len_nxt  = LEN_W'(1);
          seen_nxt = (sel_ch == CH_POINT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_IDLE;
      len_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    ch_r       <= ch_nxt;
    end_r      <= end_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
